### sv/text_console_character_writer_macros.svh
// ---------------------------------------------------------------------------
// text console character writer assertion macros
// shared property wrappers, clocked on clk and held off while rst_n is low
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TCCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console check failed");

// consequent must hold in the cycle after the antecedent
`define TCCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console check failed");

`endif

### sv/tccw_pkg.sv
// ---------------------------------------------------------------------------
// tccw_pkg
// types, constants and helpers shared by the text console writer modules
// ---------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

  // console geometry
  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int SCREEN_WORDS = COLUMNS * ROWS;

  // memory geometry, a power of two so addresses wrap by truncation
  localparam int ADDR_W       = 13;
  localparam int MEMORY_WORDS = 1 << ADDR_W;

  localparam int DATA_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int CMD_W     = 2;
  localparam int COL_W     = $clog2(COLUMNS + 1);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int CNT_W     = $clog2(MEMORY_WORDS + 1);
  localparam int CFG_IDX_W = 1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATTRIBUTE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_WORD = 1'd1;

  // reset values
  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;
  localparam logic [DATA_W-1:0] ERASE_RESET = 16'h0720;

  // control codes
  localparam logic [CHAR_W-1:0] CODE_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CODE_BEL = 8'h07;
  localparam logic [CHAR_W-1:0] CODE_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_VT  = 8'h0B;
  localparam logic [CHAR_W-1:0] CODE_FF  = 8'h0C;
  localparam logic [CHAR_W-1:0] CODE_CR  = 8'h0D;
  localparam logic [CHAR_W-1:0] CODE_DEL = 8'h7F;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [ADDR_W-1:0] cursor_address;
    logic [ADDR_W-1:0] window_start;
  } out_item_t;

  typedef enum logic [2:0] {
    CH_IGNORE,
    CH_BACKSPACE,
    CH_LINE_FEED,
    CH_FORM_FEED,
    CH_RETURN,
    CH_DELETE,
    CH_PRINT
  } char_class_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_CLEAR,
    S_NEWLINE,
    S_BLANK_BELOW,
    S_COPY,
    S_BLANK_BASE,
    S_AFTER
  } ctrl_state_t;

  typedef enum logic [1:0] {
    AFTER_DONE,
    AFTER_RETURN,
    AFTER_PRINT
  } after_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_READ,
    OP_PRINT,
    OP_BACKSPACE,
    OP_DELETE,
    OP_WRAP_BACK,
    OP_LINE_DOWN,
    OP_RETURN,
    OP_SCROLL_STEP,
    OP_REBASE,
    OP_HOME,
    OP_FILL_ALL,
    OP_FILL_BELOW,
    OP_FILL_BASE,
    OP_COPY_BACK
  } dp_op_t;

  typedef struct packed {
    logic   load_item;
    dp_op_t op;
    logic   finish;
    logic   finish_read;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    char_class_t      char_class;
    logic             col_zero;
    logic             col_full;
    logic             last_row;
    logic             room;
    logic             sweep_busy;
    logic             slot_free;
  } dp_sts_t;

  function automatic char_class_t classify(logic [CHAR_W-1:0] code);
    char_class_t cls;
    case (code)
      CODE_NUL, CODE_BEL, CODE_TAB, CODE_VT: cls = CH_IGNORE;
      CODE_BS:  cls = CH_BACKSPACE;
      CODE_LF:  cls = CH_LINE_FEED;
      CODE_FF:  cls = CH_FORM_FEED;
      CODE_CR:  cls = CH_RETURN;
      CODE_DEL: cls = CH_DELETE;
      default:  cls = CH_PRINT;
    endcase
    return cls;
  endfunction

endpackage

`default_nettype wire

### sv/tccw_ctrl.sv
// ---------------------------------------------------------------------------
// tccw_ctrl
// sequencer for put, read and clear requests of the text console writer
// ---------------------------------------------------------------------------
`default_nettype none

module tccw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tccw_pkg::dp_sts_t sts,
  output tccw_pkg::dp_cmd_t      cmd
);
  import tccw_pkg::*;

  ctrl_state_t state_r, state_nxt;
  after_t      after_r, after_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      after_r <= AFTER_DONE;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    after_nxt       = after_r;
    in_ready        = 1'b0;
    cmd.load_item   = 1'b0;
    cmd.op          = OP_NONE;
    cmd.finish      = 1'b0;
    cmd.finish_read = 1'b0;

    case (state_r)
      S_INIT: begin
        if (!sts.sweep_busy) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (sts.command)
          CMD_READ: begin
            cmd.op    = OP_READ;
            state_nxt = S_READ;
          end
          CMD_CLEAR: begin
            cmd.op    = OP_FILL_ALL;
            state_nxt = S_CLEAR;
          end
          CMD_PUT: begin
            case (sts.char_class)
              CH_PRINT: begin
                if (sts.col_full) begin
                  // deferred wrap: back to column 0, then a newline
                  cmd.op    = OP_WRAP_BACK;
                  after_nxt = AFTER_PRINT;
                  state_nxt = S_NEWLINE;
                end else if (sts.slot_free) begin
                  cmd.op     = OP_PRINT;
                  cmd.finish = 1'b1;
                  state_nxt  = S_IDLE;
                end
              end
              CH_LINE_FEED: begin
                after_nxt = AFTER_RETURN;
                state_nxt = S_NEWLINE;
              end
              CH_FORM_FEED: begin
                after_nxt = AFTER_DONE;
                state_nxt = S_NEWLINE;
              end
              CH_RETURN: begin
                if (sts.slot_free) begin
                  cmd.op     = OP_RETURN;
                  cmd.finish = 1'b1;
                  state_nxt  = S_IDLE;
                end
              end
              CH_BACKSPACE: begin
                if (sts.slot_free) begin
                  cmd.op     = sts.col_zero ? OP_NONE : OP_BACKSPACE;
                  cmd.finish = 1'b1;
                  state_nxt  = S_IDLE;
                end
              end
              CH_DELETE: begin
                if (sts.slot_free) begin
                  cmd.op     = OP_DELETE;
                  cmd.finish = 1'b1;
                  state_nxt  = S_IDLE;
                end
              end
              default: begin
                if (sts.slot_free) begin
                  cmd.finish = 1'b1;
                  state_nxt  = S_IDLE;
                end
              end
            endcase
          end
          default: begin
            if (sts.slot_free) begin
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
        endcase
      end

      S_READ: begin
        if (sts.slot_free) begin
          cmd.finish      = 1'b1;
          cmd.finish_read = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      S_CLEAR: begin
        if (!sts.sweep_busy && sts.slot_free) begin
          cmd.op     = OP_HOME;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      S_NEWLINE: begin
        if (!sts.last_row) begin
          cmd.op    = OP_LINE_DOWN;
          state_nxt = S_AFTER;
        end else if (sts.room) begin
          cmd.op    = OP_FILL_BELOW;
          state_nxt = S_BLANK_BELOW;
        end else begin
          cmd.op    = OP_COPY_BACK;
          state_nxt = S_COPY;
        end
      end

      S_BLANK_BELOW: begin
        if (!sts.sweep_busy) begin
          cmd.op    = OP_SCROLL_STEP;
          state_nxt = S_AFTER;
        end
      end

      S_COPY: begin
        if (!sts.sweep_busy) begin
          cmd.op    = OP_FILL_BASE;
          state_nxt = S_BLANK_BASE;
        end
      end

      S_BLANK_BASE: begin
        if (!sts.sweep_busy) begin
          cmd.op    = OP_REBASE;
          state_nxt = S_AFTER;
        end
      end

      S_AFTER: begin
        if (sts.slot_free) begin
          case (after_r)
            AFTER_PRINT:  cmd.op = OP_PRINT;
            AFTER_RETURN: cmd.op = OP_RETURN;
            default:      cmd.op = OP_NONE;
          endcase
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/tccw_datapath.sv
// ---------------------------------------------------------------------------
// tccw_datapath
// character memory, cursor and window registers, sweep engine and result
// register of the text console writer
// ---------------------------------------------------------------------------
`default_nettype none

module tccw_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire tccw_pkg::in_item_t                   in_data,
  output tccw_pkg::out_item_t                       out_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [tccw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tccw_pkg::DATA_W-1:0]          cfg_data,
  input  wire tccw_pkg::dp_cmd_t                    cmd,
  output tccw_pkg::dp_sts_t                         sts
);
  import tccw_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_COLS = ADDR_W'(COLUMNS);

  logic [DATA_W-1:0] mem [MEMORY_WORDS];

  in_item_t          item_r;
  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [ADDR_W-1:0] view_r, view_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ATTR_W-1:0] attr_r;
  logic [DATA_W-1:0] erase_r;

  logic [CNT_W-1:0]  swp_left_r, swp_left_nxt;
  logic [ADDR_W-1:0] swp_addr_r, swp_addr_nxt;
  logic [ADDR_W-1:0] swp_dst_r, swp_dst_nxt;
  logic              swp_copy_r, swp_copy_nxt;
  logic              swp_init_r, swp_init_nxt;
  logic              cp_pend_r, cp_pend_nxt;
  logic [ADDR_W-1:0] cp_dst_r, cp_dst_nxt;
  logic              swp_active;

  logic [DATA_W-1:0] rd_r;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;

  out_item_t         out_r;
  logic              out_valid_r;

  logic [ADDR_W-1:0] col_ext;
  logic [ADDR_W-1:0] cursor_dec;

  assign col_ext    = {{(ADDR_W-COL_W){1'b0}}, col_r};
  assign cursor_dec = cursor_r - ADDR_W'(1);
  assign swp_active = (swp_left_r != '0);

  always_comb begin
    cursor_nxt   = cursor_r;
    view_nxt     = view_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    swp_left_nxt = swp_left_r;
    swp_addr_nxt = swp_addr_r;
    swp_dst_nxt  = swp_dst_r;
    swp_copy_nxt = swp_copy_r;
    swp_init_nxt = swp_init_r;
    cp_pend_nxt  = 1'b0;
    cp_dst_nxt   = cp_dst_r;
    rd_en        = 1'b0;
    rd_addr      = swp_addr_r;
    wr_en        = 1'b0;
    wr_addr      = cursor_r;
    wr_data      = erase_r;

    // write stage of the copy, one word behind its read
    if (cp_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = cp_dst_r;
      wr_data = rd_r;
    end

    if (swp_active) begin
      swp_left_nxt = swp_left_r - CNT_W'(1);
      swp_addr_nxt = swp_addr_r + ADDR_W'(1);
      if (swp_copy_r) begin
        rd_en       = 1'b1;
        rd_addr     = swp_addr_r;
        cp_pend_nxt = 1'b1;
        cp_dst_nxt  = swp_dst_r;
        swp_dst_nxt = swp_dst_r + ADDR_W'(1);
      end else begin
        wr_en   = 1'b1;
        wr_addr = swp_addr_r;
        wr_data = swp_init_r ? ERASE_RESET : erase_r;
      end
    end

    case (cmd.op)
      OP_READ: begin
        rd_en   = 1'b1;
        rd_addr = item_r.read_address;
      end
      OP_PRINT: begin
        wr_en      = 1'b1;
        wr_addr    = cursor_r;
        wr_data    = {attr_r, item_r.char_code};
        cursor_nxt = cursor_r + ADDR_W'(1);
        col_nxt    = col_r + COL_W'(1);
      end
      OP_BACKSPACE: begin
        wr_en      = 1'b1;
        wr_addr    = cursor_dec;
        wr_data    = erase_r;
        cursor_nxt = cursor_dec;
        col_nxt    = col_r - COL_W'(1);
      end
      OP_DELETE: begin
        wr_en   = 1'b1;
        wr_addr = cursor_r;
        wr_data = erase_r;
      end
      OP_WRAP_BACK: begin
        cursor_nxt = cursor_r - ADDR_COLS;
        col_nxt    = col_r - COL_W'(COLUMNS);
      end
      OP_LINE_DOWN: begin
        row_nxt    = row_r + ROW_W'(1);
        cursor_nxt = cursor_r + ADDR_COLS;
      end
      OP_RETURN: begin
        cursor_nxt = cursor_r - col_ext;
        col_nxt    = '0;
      end
      OP_SCROLL_STEP: begin
        view_nxt   = view_r + ADDR_COLS;
        cursor_nxt = cursor_r + ADDR_COLS;
      end
      OP_REBASE: begin
        cursor_nxt = cursor_r - view_r;
        view_nxt   = '0;
      end
      OP_HOME: begin
        cursor_nxt = '0;
        view_nxt   = '0;
        col_nxt    = '0;
        row_nxt    = '0;
      end
      OP_FILL_ALL: begin
        swp_left_nxt = CNT_W'(MEMORY_WORDS);
        swp_addr_nxt = '0;
        swp_copy_nxt = 1'b0;
        swp_init_nxt = 1'b0;
      end
      OP_FILL_BELOW: begin
        swp_left_nxt = CNT_W'(COLUMNS);
        swp_addr_nxt = view_r + ADDR_W'(SCREEN_WORDS);
        swp_copy_nxt = 1'b0;
        swp_init_nxt = 1'b0;
      end
      OP_FILL_BASE: begin
        swp_left_nxt = CNT_W'(COLUMNS);
        swp_addr_nxt = ADDR_W'(SCREEN_WORDS - COLUMNS);
        swp_copy_nxt = 1'b0;
        swp_init_nxt = 1'b0;
      end
      OP_COPY_BACK: begin
        swp_left_nxt = CNT_W'(SCREEN_WORDS - COLUMNS);
        swp_addr_nxt = view_r + ADDR_COLS;
        swp_dst_nxt  = '0;
        swp_copy_nxt = 1'b1;
        swp_init_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // control and console state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      view_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= ATTR_RESET;
      erase_r     <= ERASE_RESET;
      // reset starts a full pass of the reset blank word
      swp_left_r  <= CNT_W'(MEMORY_WORDS);
      swp_addr_r  <= '0;
      swp_dst_r   <= '0;
      swp_copy_r  <= 1'b0;
      swp_init_r  <= 1'b1;
      cp_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_r   <= cursor_nxt;
      view_r     <= view_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      swp_left_r <= swp_left_nxt;
      swp_addr_r <= swp_addr_nxt;
      swp_dst_r  <= swp_dst_nxt;
      swp_copy_r <= swp_copy_nxt;
      swp_init_r <= swp_init_nxt;
      cp_pend_r  <= cp_pend_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ATTRIBUTE:  attr_r  <= cfg_data[ATTR_W-1:0];
          CFG_ERASE_WORD: erase_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cp_dst_r <= cp_dst_nxt;
    if (cmd.load_item) item_r <= in_data;
    if (cmd.finish) begin
      out_r.read_data      <= cmd.finish_read ? rd_r : '0;
      out_r.cursor_address <= cursor_nxt;
      out_r.window_start   <= view_nxt;
    end
  end

  // character memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_r <= mem[rd_addr];
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts.command    = item_r.command;
    sts.char_class = classify(item_r.char_code);
    sts.col_zero   = (col_r == '0);
    sts.col_full   = (col_r >= COL_W'(COLUMNS));
    sts.last_row   = (row_r == ROW_W'(ROWS - 1));
    sts.room       = (({1'b0, view_r} + (ADDR_W+1)'(SCREEN_WORDS + COLUMNS))
                      < (ADDR_W+1)'(MEMORY_WORDS));
    sts.sweep_busy = swp_active || cp_pend_r;
    sts.slot_free  = !out_valid_r || out_ready;
  end

endmodule

`default_nettype wire

### sv/text_console_character_writer.sv
// ---------------------------------------------------------------------------
// text console character writer
// 80x25 text console over an 8192-word character memory with a sliding window
// ---------------------------------------------------------------------------
// use:
//   in_*  : one request per item (command, char_code, read_address)
//   out_* : exactly one result per request, in order (read_data,
//           cursor_address, window_start)
//   cfg_* : register writes (0 attribute, 1 erase word), always ready
// work per request, one in flight at a time, from accept to result load:
//   print without wrap, backspace, delete, return, ignored codes and command 3:
//   done at dispatch; read: result from the registered memory read port
//   newline (line feed, form feed, wrap) without scroll: a line-down step
//   scroll: an 80-word blank sweep of the row below the window
//   copy-back at memory end: a 1920-word copy, then an 80-word blank
//   clear: an 8192-word fill, one memory word written per cycle
// reset: a clearing pass fills all 8192 memory words with 0x0720 while
//   in_ready stays low; configuration writes are taken during the pass
// stall: a result waits in the output register; one more request is taken
//   and its work stops at the point where its result would be loaded
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_character_writer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire tccw_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output tccw_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tccw_pkg::DATA_W-1:0]    cfg_data
);
  import tccw_pkg::*;

  `include "text_console_character_writer_macros.svh"

  // command and status between sequencer and datapath
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencer: decodes the request, walks newline and scroll steps
  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  // datapath: memory, cursor and window, sweep engine, result register
  tccw_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  // one request in flight at a time
  `TCCW_ASSERT_NEXT(a_single_request, in_valid && in_ready, !in_ready)
  // no request taken while a memory sweep runs
  `TCCW_ASSERT_NOW(a_no_accept_in_sweep, dp_sts.sweep_busy, !in_ready)
  // a result is only loaded when the output register is free
  `TCCW_ASSERT_NOW(a_finish_into_free_slot, dp_cmd.finish, dp_sts.slot_free)
  // every new result comes from a finished request
  `TCCW_ASSERT_NOW(a_result_from_finish, $rose(out_valid), $past(dp_cmd.finish))

endmodule

`default_nettype wire

### dv/console_check.sv
// ---------------------------------------------------------------------------
// console_check
// watches the request, result and register channels of the text console
// writer, keeps its own copy of the character memory, cursor and window,
// and compares every result against the predicted one, in order
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module console_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  tccw_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  tccw_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tccw_pkg::DATA_W-1:0]    cfg_data,
  output int                             pending,
  output int                             fail_count
);
  import tccw_pkg::*;

  localparam int LINE_WORDS   = 80;
  localparam int SCREEN_LINES = 25;
  localparam int VIEW_WORDS   = LINE_WORDS * SCREEN_LINES;
  localparam int STORE_WORDS  = 8192;

  typedef logic [ADDR_W-1:0] addr_t;

  // console image, addresses wrap by truncation to 13 bits
  logic [DATA_W-1:0] cells [STORE_WORDS];
  addr_t             cursor_at;
  addr_t             view_at;
  int                column_no;
  int                row_no;
  logic [ATTR_W-1:0] attr_byte;
  logic [DATA_W-1:0] blank_word;

  out_item_t predicted_reports[$];

  function void wipe_console();
    for (int i = 0; i < STORE_WORDS; i++) cells[addr_t'(i)] = blank_word;
    cursor_at = '0;
    view_at   = '0;
    column_no = 0;
    row_no    = 0;
  endfunction

  function void scroll_view();
    if (int'(view_at) + VIEW_WORDS + LINE_WORDS < STORE_WORDS) begin
      // blank the line below the window, then slide by one line
      for (int i = 0; i < LINE_WORDS; i++)
        cells[addr_t'(int'(view_at) + VIEW_WORDS + i)] = blank_word;
      view_at   = view_at + addr_t'(LINE_WORDS);
      cursor_at = cursor_at + addr_t'(LINE_WORDS);
    end else begin
      // memory end: copy lines 1.. back to base, blank the last base line
      for (int i = 0; i < VIEW_WORDS - LINE_WORDS; i++)
        cells[addr_t'(i)] = cells[addr_t'(int'(view_at) + LINE_WORDS + i)];
      for (int i = VIEW_WORDS - LINE_WORDS; i < VIEW_WORDS; i++)
        cells[addr_t'(i)] = blank_word;
      cursor_at = cursor_at - view_at;
      view_at   = '0;
    end
  endfunction

  function void line_down();
    if (row_no + 1 < SCREEN_LINES) begin
      row_no++;
      cursor_at = cursor_at + addr_t'(LINE_WORDS);
    end else begin
      scroll_view();
    end
  endfunction

  function void carriage_return();
    cursor_at = cursor_at - addr_t'(column_no);
    column_no = 0;
  endfunction

  function void put_char(logic [CHAR_W-1:0] ch);
    case (ch)
      CODE_NUL, CODE_BEL, CODE_TAB, CODE_VT: ;
      CODE_BS: begin
        if (column_no != 0) begin
          column_no--;
          cursor_at = cursor_at - addr_t'(1);
          cells[cursor_at] = blank_word;
        end
      end
      CODE_LF: begin
        line_down();
        carriage_return();
      end
      CODE_FF:  line_down();
      CODE_CR:  carriage_return();
      CODE_DEL: cells[cursor_at] = blank_word;
      default: begin
        // deferred wrap to the start of the next line
        if (column_no >= LINE_WORDS) begin
          column_no -= LINE_WORDS;
          cursor_at = cursor_at - addr_t'(LINE_WORDS);
          line_down();
        end
        cells[cursor_at] = {attr_byte, ch};
        cursor_at = cursor_at + addr_t'(1);
        column_no++;
      end
    endcase
  endfunction

  function out_item_t apply_request(in_item_t r);
    out_item_t o;
    o.read_data = '0;
    case (r.command)
      CMD_PUT:   put_char(r.char_code);
      CMD_READ:  o.read_data = cells[r.read_address];
      CMD_CLEAR: wipe_console();
      default: ;
    endcase
    o.cursor_address = cursor_at;
    o.window_start   = view_at;
    return o;
  endfunction

  function void check_field(string label, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, label, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      attr_byte  = ATTR_RESET;
      blank_word = ERASE_RESET;
      wipe_console();
      predicted_reports.delete();
      pending    = 0;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ATTRIBUTE) attr_byte = cfg_data[ATTR_W-1:0];
        else if (cfg_index == CFG_ERASE_WORD) blank_word = cfg_data;
      end
      // a result at this edge belongs to an earlier request
      if (out_valid && out_ready) begin
        if (predicted_reports.size() == 0) begin
          $display("%0t: result expected none, actual %p", $time, out_data);
          fail_count++;
        end else begin
          want = predicted_reports.pop_front();
          check_field("read_data", 32'(want.read_data), 32'(out_data.read_data));
          check_field("cursor_address", 32'(want.cursor_address),
                      32'(out_data.cursor_address));
          check_field("window_start", 32'(want.window_start),
                      32'(out_data.window_start));
        end
      end
      if (in_valid && in_ready) predicted_reports.push_back(apply_request(in_data));
      pending = predicted_reports.size();
    end
  end

endmodule

### dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// stimulus and verdict for the text console character writer: a directed
// pass over every control code and field extreme, then phases of random
// requests (long text lines, newline floods that drive the window to the
// memory end, mixed editing) with register settings changed between phases
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import tccw_pkg::*;

  // command code the block ignores
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 127;

  typedef enum {TEXT_RUN, SCROLL_FLOOD, MIXED_EDIT} flavor_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  int pending;
  int fail_count;

  // phases with no idling on either side
  bit steady_send;
  bit steady_take;
  // clears are slow, so cap the random ones
  int clears_left;

  text_console_character_writer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  console_check check_u (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_len(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_item(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                         logic [ADDR_W-1:0] addr);
    in_item_t r;
    r.command      = cmd;
    r.char_code    = ch;
    r.read_address = addr;
    return r;
  endfunction

  // byte mix for put requests, shaped per phase flavor
  function automatic logic [CHAR_W-1:0] pick_char(flavor_t flavor);
    int r;
    int lf_top, ff_top, text_top, bs_top, del_top, cr_top, ign_top;
    r = $urandom_range(0, 99);
    case (flavor)
      TEXT_RUN: begin
        lf_top = 2; ff_top = 3; text_top = 83; bs_top = 87; del_top = 90;
        cr_top = 92; ign_top = 96;
      end
      SCROLL_FLOOD: begin
        lf_top = 50; ff_top = 65; text_top = 88; bs_top = 92; del_top = 95;
        cr_top = 97; ign_top = 98;
      end
      default: begin
        lf_top = 15; ff_top = 20; text_top = 65; bs_top = 75; del_top = 82;
        cr_top = 88; ign_top = 92;
      end
    endcase
    if (r < lf_top) return CODE_LF;
    if (r < ff_top) return CODE_FF;
    if (r < text_top) begin
      // mostly plain ascii, sometimes any byte at all
      if ($urandom_range(0, 3) != 0) return CHAR_W'($urandom_range(8'h20, 8'h7E));
      return CHAR_W'($urandom);
    end
    if (r < bs_top) return CODE_BS;
    if (r < del_top) return CODE_DEL;
    if (r < cr_top) return CODE_CR;
    if (r < ign_top) begin
      case ($urandom_range(0, 3))
        0: return CODE_NUL;
        1: return CODE_BEL;
        2: return CODE_TAB;
        default: return CODE_VT;
      endcase
    end
    return CHAR_W'($urandom_range(0, 31));
  endfunction

  // read addresses: base area where copy-back lands, the top end, anywhere
  function automatic logic [ADDR_W-1:0] pick_address();
    case ($urandom_range(0, 2))
      0: return ADDR_W'($urandom_range(0, 2047));
      1: return ADDR_W'($urandom_range(6000, 8191));
      default: return ADDR_W'($urandom);
    endcase
  endfunction

  // one request; valid stays up after acceptance until the next call or a settle
  task automatic send_request(in_item_t r);
    int gap;
    gap = idle_len(steady_send);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and hold off until every predicted result has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // extremes and reset values in the first phases, random after that
  task automatic program_registers(int p);
    logic [ATTR_W-1:0] attr;
    logic [DATA_W-1:0] erase;
    case (p)
      0: begin
        attr  = '0;
        erase = '0;
      end
      1: begin
        attr  = '1;
        erase = '1;
      end
      2: begin
        attr  = ATTR_RESET;
        erase = ERASE_RESET;
      end
      default: begin
        attr  = ATTR_W'($urandom);
        erase = DATA_W'($urandom);
      end
    endcase
    // upper byte of an attribute write is junk the block must drop
    if ($urandom_range(0, 1) != 0) begin
      write_register(CFG_ATTRIBUTE, {ATTR_W'($urandom), attr});
      write_register(CFG_ERASE_WORD, erase);
    end else begin
      write_register(CFG_ERASE_WORD, erase);
      write_register(CFG_ATTRIBUTE, {ATTR_W'($urandom), attr});
    end
  endtask

  // every control code, field extremes, command 3 and a clear
  task automatic run_directed();
    in_item_t seq[$];
    seq.push_back(make_item(CMD_READ, '0, '0));
    seq.push_back(make_item(CMD_READ, '1, '1));
    seq.push_back(make_item(CMD_PUT, 8'h41, '1));
    seq.push_back(make_item(CMD_PUT, 8'hFF, '0));
    seq.push_back(make_item(CMD_PUT, 8'h80, '1));
    seq.push_back(make_item(CMD_READ, '0, '0));
    seq.push_back(make_item(CMD_PUT, CODE_NUL, '0));
    seq.push_back(make_item(CMD_PUT, CODE_BEL, '0));
    seq.push_back(make_item(CMD_PUT, CODE_TAB, '0));
    seq.push_back(make_item(CMD_PUT, CODE_VT, '0));
    // backspace erases the third cell, delete the one under the cursor
    seq.push_back(make_item(CMD_PUT, CODE_BS, '0));
    seq.push_back(make_item(CMD_PUT, CODE_DEL, '0));
    seq.push_back(make_item(CMD_PUT, CODE_CR, '0));
    // backspace at column zero does nothing
    seq.push_back(make_item(CMD_PUT, CODE_BS, '0));
    seq.push_back(make_item(CMD_PUT, CODE_LF, '0));
    seq.push_back(make_item(CMD_PUT, CODE_FF, '0));
    seq.push_back(make_item(CMD_PUT, 8'h20, '0));
    seq.push_back(make_item(CMD_NOP, '1, '1));
    seq.push_back(make_item(CMD_READ, '0, ADDR_W'(160)));
    seq.push_back(make_item(CMD_READ, '0, ADDR_W'(2)));
    seq.push_back(make_item(CMD_CLEAR, '1, '1));
    seq.push_back(make_item(CMD_READ, '0, ADDR_W'(80)));
    seq.push_back(make_item(CMD_PUT, 8'h7E, '1));
    foreach (seq[i]) send_request(seq[i]);
  endtask

  task automatic run_phase(flavor_t flavor, int n);
    int roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 999);
      if (roll < 4 && clears_left > 0) begin
        clears_left--;
        send_request(make_item(CMD_CLEAR, CHAR_W'($urandom), ADDR_W'($urandom)));
      end else if (roll < 20) begin
        send_request(make_item(CMD_NOP, CHAR_W'($urandom), ADDR_W'($urandom)));
      end else if (roll < 130) begin
        send_request(make_item(CMD_READ, CHAR_W'($urandom), pick_address()));
      end else begin
        send_request(make_item(CMD_PUT, pick_char(flavor), ADDR_W'($urandom)));
      end
      // now and then the sender waits for the pipe to drain
      if ($urandom_range(0, 199) == 0) settle();
    end
  endtask

  // result side: ready runs broken by random stalls
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      stall = idle_len(steady_take);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    steady_send = 1'b0;
    steady_take = 1'b0;
    clears_left = 10;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // the first request waits out the clearing pass through in_ready
    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      // registers only change with nothing in flight
      settle();
      program_registers(p);
      steady_send = (p % 4 == 2);
      steady_take = (p % 5 == 3);
      if (p == 5 || p == 10)
        send_request(make_item(CMD_CLEAR, CHAR_W'($urandom), ADDR_W'($urandom)));
      run_phase(flavor_t'(p % 3), PHASE_ITEMS);
    end

    settle();
    // catch any stray result after the last one
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard
  initial begin
    #30ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/tccw_pkg.sv
sv/tccw_ctrl.sv
sv/tccw_datapath.sv
sv/text_console_character_writer.sv
dv/console_check.sv
dv/tb.sv
